/* hdl/i2cem_pkg.sv */
// ----------------------------------------------------------------------------
// i2cem_pkg - shared types and codes of the i2c error monitor
// Item and result layouts, mode, error and register codes, recovery phases.
// ----------------------------------------------------------------------------
package i2cem_pkg;

    // bus-clear pulse limit and statistics counter width
    localparam logic [3:0] PULSE_LIMIT   = 4'd9;
    localparam int         COUNTER_WIDTH = 32;

    typedef logic [COUNTER_WIDTH-1:0] t_cnt;

    // item modes
    localparam logic [1:0] MODE_RESULT      = 2'd0;
    localparam logic [1:0] MODE_TICK        = 2'd1;
    localparam logic [1:0] MODE_REINIT_DONE = 2'd2;
    localparam logic [1:0] MODE_CLEAR       = 2'd3;

    // transaction result codes
    localparam logic [7:0] ERR_OK        = 8'd0;
    localparam logic [7:0] ERR_TOO_LONG  = 8'd1;
    localparam logic [7:0] ERR_ADDR_NACK = 8'd2;
    localparam logic [7:0] ERR_DATA_NACK = 8'd3;
    localparam logic [7:0] ERR_BUS       = 8'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_PINS      = 2'd1;
    localparam logic [1:0] CFG_REINIT    = 2'd2;
    localparam logic [1:0] CFG_VIEW      = 2'd3;

    // statistic views
    localparam logic [2:0] VIEW_TOTAL     = 3'd0;
    localparam logic [2:0] VIEW_NACK      = 3'd1;
    localparam logic [2:0] VIEW_BUS       = 3'd2;
    localparam logic [2:0] VIEW_ATTEMPTS  = 3'd3;
    localparam logic [2:0] VIEW_SUCCESSES = 3'd4;
    localparam logic [2:0] VIEW_LAST_TIME = 3'd5;

    // recovery phases
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_SAMPLE     = 4'd1,
        PH_PULSE_LOW  = 4'd2,
        PH_PULSE_HIGH = 4'd3,
        PH_STOP_LOW   = 4'd4,
        PH_STOP_HIGH  = 4'd5,
        PH_CHECK      = 4'd6,
        PH_RESET      = 4'd7,
        PH_RECHECK    = 4'd8
    } t_phase;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  error_code;
        logic [31:0] timestamp;
        logic        sda_level;
        logic        scl_level;
    } t_item;

    typedef struct packed {
        logic        handled_ok;
        logic        recovery_started;
        logic        recovery_busy;
        logic        recovery_done;
        logic        recovery_ok;
        logic        scl_drive_low;
        logic        sda_drive_low;
        logic        controller_reset;
        logic        reinit_request;
        logic [7:0]  consecutive_count;
        logic [31:0] stat_value;
    } t_result;

endpackage

/* hdl/i2cem_in_reg.sv */
// ----------------------------------------------------------------------------
// i2cem_in_reg - input register stage
// Holds one accepted beat until the core consumes it.
// ----------------------------------------------------------------------------
module i2cem_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  i2cem_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_valid,
    output i2cem_pkg::t_item o_item
);
    import i2cem_pkg::*;

    logic  r_vld;
    t_item r_item;

    // free when empty or when the held beat moves on this cycle
    assign o_ready = !r_vld || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

/* hdl/i2cem_core.sv */
// ----------------------------------------------------------------------------
// i2cem_core - error statistics and bus-clear recovery sequencer
// Configuration registers, written on each configuration strobe; counters and
// the recovery phase machine, updated once per consumed beat.
// ----------------------------------------------------------------------------
module i2cem_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_fire,
    input  i2cem_pkg::t_item   i_item,
    output i2cem_pkg::t_result o_result
);
    import i2cem_pkg::*;

    // configuration
    logic [7:0] r_thr;
    logic       r_pins;
    logic       r_reinit_en;
    logic [2:0] r_view;

    // state
    t_phase      r_phase,   n_phase;
    logic [3:0]  r_pulse,   n_pulse;
    logic [7:0]  r_cons,    n_cons;
    t_cnt        r_total,   n_total;
    t_cnt        r_nack,    n_nack;
    t_cnt        r_bus,     n_bus;
    t_cnt        r_attempt, n_attempt;
    t_cnt        r_success, n_success;
    logic [31:0] r_last,    n_last;
    logic        r_pend,    n_pend;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == '1) ? v : v + t_cnt'(1);
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= 8'd3;
            r_pins      <= 1'b1;
            r_reinit_en <= 1'b0;
            r_view      <= VIEW_TOTAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_thr       <= i_cfg_data;
                CFG_PINS:      r_pins      <= i_cfg_data[0];
                CFG_REINIT:    r_reinit_en <= i_cfg_data[0];
                CFG_VIEW:      r_view      <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pulse   <= 4'd0;
            r_cons    <= 8'd0;
            r_total   <= '0;
            r_nack    <= '0;
            r_bus     <= '0;
            r_attempt <= '0;
            r_success <= '0;
            r_last    <= 32'd0;
            r_pend    <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_pulse   <= n_pulse;
            r_cons    <= n_cons;
            r_total   <= n_total;
            r_nack    <= n_nack;
            r_bus     <= n_bus;
            r_attempt <= n_attempt;
            r_success <= n_success;
            r_last    <= n_last;
            r_pend    <= n_pend;
        end
    end

    // next state and result for the beat at the input register
    always_comb begin
        logic       busy;
        logic       eligible;
        logic       fin;
        logic       fin_ok;
        logic       line_ok;
        logic [7:0] cons_inc;
        logic [3:0] pulse_inc;
        logic [63:0] sel_wide;

        busy      = (r_phase != PH_IDLE);
        eligible  = 1'b0;
        fin       = 1'b0;
        fin_ok    = 1'b0;
        line_ok   = !r_pins || (i_item.sda_level && i_item.scl_level);
        cons_inc  = (r_cons == 8'hFF) ? r_cons : r_cons + 8'd1;
        pulse_inc = (r_pulse == 4'hF) ? r_pulse : r_pulse + 4'd1;
        sel_wide  = 64'd0;

        n_phase   = r_phase;
        n_pulse   = r_pulse;
        n_cons    = r_cons;
        n_total   = r_total;
        n_nack    = r_nack;
        n_bus     = r_bus;
        n_attempt = r_attempt;
        n_success = r_success;
        n_last    = r_last;
        n_pend    = r_pend;
        o_result  = '0;

        unique case (i_item.mode)
            MODE_RESULT: begin
                if (i_item.error_code == ERR_OK) begin
                    n_cons              = 8'd0;
                    o_result.handled_ok = 1'b1;
                end else begin
                    n_total = sat_inc(r_total);
                    n_last  = i_item.timestamp;
                    n_cons  = cons_inc;
                    case (i_item.error_code) inside
                        ERR_TOO_LONG: n_cons = 8'd0;
                        ERR_ADDR_NACK, ERR_DATA_NACK: begin
                            n_nack   = sat_inc(r_nack);
                            eligible = 1'b1;
                        end
                        ERR_BUS: begin
                            n_bus    = sat_inc(r_bus);
                            eligible = 1'b1;
                        end
                        default: ;
                    endcase
                    // threshold reached with the bus free to recover
                    if (eligible && n_cons >= r_thr && !r_pend && !busy) begin
                        n_attempt                 = sat_inc(r_attempt);
                        n_phase                   = PH_SAMPLE;
                        n_pulse                   = 4'd0;
                        o_result.recovery_started = 1'b1;
                    end
                end
            end
            MODE_TICK: begin
                unique case (r_phase)
                    PH_SAMPLE: begin
                        if (!r_pins) begin
                            n_phase = PH_RESET;
                        end else if (i_item.sda_level) begin
                            n_phase = PH_CHECK;
                        end else begin
                            n_pulse = 4'd0;
                            n_phase = PH_PULSE_LOW;
                        end
                    end
                    PH_PULSE_LOW: begin
                        o_result.scl_drive_low = 1'b1;
                        n_phase                = PH_PULSE_HIGH;
                    end
                    PH_PULSE_HIGH: begin
                        n_pulse = pulse_inc;
                        if (i_item.sda_level || pulse_inc >= PULSE_LIMIT) begin
                            n_phase = PH_STOP_LOW;
                        end else begin
                            n_phase = PH_PULSE_LOW;
                        end
                    end
                    PH_STOP_LOW: begin
                        o_result.sda_drive_low = 1'b1;
                        n_phase                = PH_STOP_HIGH;
                    end
                    PH_STOP_HIGH: n_phase = PH_CHECK;
                    PH_CHECK: begin
                        if (line_ok) begin
                            fin    = 1'b1;
                            fin_ok = 1'b1;
                        end else begin
                            n_phase = PH_RESET;
                        end
                    end
                    PH_RESET: begin
                        o_result.controller_reset = 1'b1;
                        n_phase                   = PH_RECHECK;
                    end
                    PH_RECHECK: begin
                        fin    = 1'b1;
                        fin_ok = line_ok;
                    end
                    default: ;
                endcase
                // end of the sequence
                if (fin) begin
                    n_phase                = PH_IDLE;
                    n_pulse                = 4'd0;
                    o_result.recovery_done = 1'b1;
                    if (fin_ok) begin
                        o_result.recovery_ok = 1'b1;
                        o_result.handled_ok  = 1'b1;
                        n_success            = sat_inc(r_success);
                        n_cons               = 8'd0;
                        if (r_reinit_en) begin
                            n_pend = 1'b1;
                        end
                    end
                end
            end
            MODE_REINIT_DONE: begin
                n_pend = 1'b0;
                n_cons = 8'd0;
            end
            MODE_CLEAR: begin
                n_total   = '0;
                n_nack    = '0;
                n_bus     = '0;
                n_attempt = '0;
                n_success = '0;
                n_last    = 32'd0;
                n_cons    = 8'd0;
            end
            default: ;
        endcase

        // statistic select
        case (r_view)
            VIEW_TOTAL:     sel_wide = 64'(n_total);
            VIEW_NACK:      sel_wide = 64'(n_nack);
            VIEW_BUS:       sel_wide = 64'(n_bus);
            VIEW_ATTEMPTS:  sel_wide = 64'(n_attempt);
            VIEW_SUCCESSES: sel_wide = 64'(n_success);
            VIEW_LAST_TIME: sel_wide = 64'(n_last);
            default:        sel_wide = 64'd0;
        endcase

        o_result.recovery_busy     = (n_phase != PH_IDLE);
        o_result.reinit_request    = n_pend;
        o_result.consecutive_count = n_cons;
        o_result.stat_value        = sel_wide[31:0];
    end

endmodule

/* hdl/i2cem_out_reg.sv */
// ----------------------------------------------------------------------------
// i2cem_out_reg - result register stage
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module i2cem_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  i2cem_pkg::t_result i_result,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output i2cem_pkg::t_result o_result
);
    import i2cem_pkg::*;

    logic    r_vld;
    t_result r_res;

    // room for a new beat when empty or being taken now
    assign o_free = !r_vld || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_valid  = r_vld;
    assign o_result = r_res;

endmodule

/* hdl/i2c_error_monitor_bus_clear.sv */
// ----------------------------------------------------------------------------
// i2c_error_monitor_bus_clear - i2c error monitor with bus-clear recovery
// Top level: input register, statistics and recovery core, result register.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the result register has room and gives exactly one
// result beat per input beat. The result beat passes the input register, then the
// result register, before it is presented. The rate is set by the update of the
// counters and recovery phase register in the core once per consumed beat; a held
// result lets one more beat into the input register before the input stalls.
// Recovery runs one phase per tick beat, so the caller spaces ticks to get the line
// settle times. Configuration writes take effect at the next edge and belong in
// idle periods.
module i2c_error_monitor_bus_clear (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_error_code,
    input  logic [31:0] i_timestamp,
    input  logic        i_sda_level,
    input  logic        i_scl_level,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_handled_ok,
    output logic        o_recovery_started,
    output logic        o_recovery_busy,
    output logic        o_recovery_done,
    output logic        o_recovery_ok,
    output logic        o_scl_drive_low,
    output logic        o_sda_drive_low,
    output logic        o_controller_reset,
    output logic        o_reinit_request,
    output logic [7:0]  o_consecutive_count,
    output logic [31:0] o_stat_value
);
    import i2cem_pkg::*;

    t_item   in_item;
    t_item   held_item;
    t_result core_res;
    t_result out_res;
    logic    held_vld;
    logic    out_free;
    logic    fire;

    assign in_item = '{mode: i_mode, error_code: i_error_code, timestamp: i_timestamp,
                       sda_level: i_sda_level, scl_level: i_scl_level};

    // a held beat is processed when the result register has room
    assign fire = held_vld && out_free;

    i2cem_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (held_vld),
        .o_item  (held_item)
    );

    i2cem_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (held_item),
        .o_result   (core_res)
    );

    i2cem_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_res),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_res)
    );

    // result fields
    assign o_handled_ok        = out_res.handled_ok;
    assign o_recovery_started  = out_res.recovery_started;
    assign o_recovery_busy     = out_res.recovery_busy;
    assign o_recovery_done     = out_res.recovery_done;
    assign o_recovery_ok       = out_res.recovery_ok;
    assign o_scl_drive_low     = out_res.scl_drive_low;
    assign o_sda_drive_low     = out_res.sda_drive_low;
    assign o_controller_reset  = out_res.controller_reset;
    assign o_reinit_request    = out_res.reinit_request;
    assign o_consecutive_count = out_res.consecutive_count;
    assign o_stat_value        = out_res.stat_value;

endmodule

/* hdl/i2cem_checker.sv */
// ----------------------------------------------------------------------------
// i2cem_checker - port-level checks of the i2c error monitor
// Consistency of result flags and hold of a stalled result beat.
// ----------------------------------------------------------------------------
module i2cem_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_handled_ok,
    input logic        o_recovery_started,
    input logic        o_recovery_busy,
    input logic        o_recovery_done,
    input logic        o_recovery_ok,
    input logic        o_scl_drive_low,
    input logic        o_sda_drive_low,
    input logic        o_controller_reset,
    input logic        o_reinit_request,
    input logic [7:0]  o_consecutive_count,
    input logic [31:0] o_stat_value
);

    // a healthy finish reports success and clears the error run
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_recovery_ok) |->
            (o_recovery_done && o_handled_ok && o_consecutive_count == 8'd0))
        else $error("recovery ok without done, handled or cleared count");

    // a finished sequence leaves nothing running
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_recovery_done) |-> !o_recovery_busy)
        else $error("recovery busy after done");

    // starting or stepping a recovery keeps it running
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_recovery_started || o_controller_reset ||
                         o_scl_drive_low || o_sda_drive_low)) |-> o_recovery_busy)
        else $error("recovery step without busy");

    // at most one line action per beat
    a_one_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            $onehot0({o_scl_drive_low, o_sda_drive_low, o_controller_reset}))
        else $error("more than one drive action");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_stat_value) && $stable(o_consecutive_count)
             && $stable(o_reinit_request) && $stable(o_handled_ok)))
        else $error("stalled result beat changed");

endmodule

bind i2c_error_monitor_bus_clear i2cem_checker u_i2cem_checker (.*);
